// ===== rtl/lld_pkg.sv =====
// Package for the least-load worker dispatcher.
// Holds sizes, command codes, item structs and controller/datapath interface types.
// No dependencies.
package lld_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int VAL_W       = 63;
  localparam int MASK_W      = 16;
  localparam int WID_W       = 4;
  localparam int REFCNT_W    = 5;
  localparam int CFG_W       = 5;
  localparam int EWMA_SHIFT  = 3;

  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_REPLY    = 1'b1;

  typedef struct packed {
    logic              command;
    logic [VAL_W-1:0]  request_time;
    logic [MASK_W-1:0] refuse_mask;
    logic [WID_W-1:0]  reply_worker;
    logic [VAL_W-1:0]  reply_cpu_time;
    logic [VAL_W-1:0]  reply_proc_time;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic [WID_W-1:0]    chosen_worker;
    logic [REFCNT_W-1:0] refused_count;
    logic [VAL_W-1:0]    reply_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic update;
    logic rep_a;
    logic rep_b;
    logic emit;
  } lld_cmd_t;

  typedef struct packed {
    logic is_reply;
    logic reply_ok;
    logic n_zero;
    logic last;
    logic out_free;
  } lld_status_t;

endpackage

// ===== rtl/lld_datapath.sv =====
// Datapath of the least-load worker dispatcher: load and prediction arrays,
// the scan and update walk, the moving-average unit and the output register.
// Depends on lld_pkg.
module lld_datapath import lld_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_item_t             in_item,
  input  lld_cmd_t             cmd,
  output lld_status_t          status,
  output out_item_t            out_item,
  output logic                 out_valid,
  input  logic                 out_stall
);

  logic [VAL_W-1:0]    load [MAX_WORKERS];
  logic [VAL_W-1:0]    pred [MAX_WORKERS];
  logic [VAL_W-1:0]    count;
  logic [CFG_W-1:0]    active;
  in_item_t            item;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    best_idx;
  logic [VAL_W-1:0]    best_load;
  logic                found;
  logic [CNT_W-1:0]    refused;
  logic [VAL_W+2:0]    ew_t;

  logic [CNT_W-1:0]       n_eff;
  logic [IDX_W-1:0]       addr;
  logic [IDX_W-1:0]       idx_next;
  logic [MAX_WORKERS-1:0] refuse_vec;
  logic                   rbit;
  logic [VAL_W-1:0]       ld;
  logic [VAL_W-1:0]       pr;
  logic                   is_best;
  logic                   ahead;
  logic [VAL_W-1:0]       add_a;
  logic [VAL_W:0]         sum;
  logic [VAL_W-1:0]       sat;
  logic [VAL_W+2:0]       ew_sum;

  always_comb begin
    n_eff = (int'(active) > MAX_WORKERS) ? CNT_W'(MAX_WORKERS) : CNT_W'(active);
    addr = (item.command == CMD_REPLY) ? IDX_W'(item.reply_worker) : idx;
    refuse_vec = MAX_WORKERS'(item.refuse_mask);
    rbit = refuse_vec[addr];
    ld = load[addr];
    pr = pred[addr];
    is_best = found && (idx == best_idx);
    ahead = !found || (ld < best_load) || ((ld == best_load) && (idx < best_idx));
    add_a = is_best ? ld : item.request_time;
    sum = {1'b0, add_a} + {1'b0, pr};
    sat = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
    ew_sum = ew_t + {3'b000, item.reply_proc_time};
    status.last = ((CNT_W+1)'(idx) + (CNT_W+1)'(1)) == (CNT_W+1)'(n_eff);
    idx_next = status.last ? '0 : idx + IDX_W'(1);
    status.is_reply = (item.command == CMD_REPLY);
    status.reply_ok = (CNT_W+1)'(item.reply_worker) < (CNT_W+1)'(n_eff);
    status.n_zero = (n_eff == '0);
    status.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cfg_write) begin
      active <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
      idx <= '0;
      found <= 1'b0;
      best_idx <= '0;
      best_load <= '0;
      refused <= '0;
    end
    if (cmd.scan) begin
      idx <= idx_next;
      if (!rbit && (!found || ld < best_load)) begin
        found <= 1'b1;
        best_idx <= idx;
        best_load <= ld;
      end
    end
    if (cmd.update) begin
      idx <= idx_next;
      if (!is_best && rbit && ahead) begin
        refused <= refused + CNT_W'(1);
      end
    end
    if (cmd.rep_a) begin
      ew_t <= {pr, 3'b000} - {3'b000, pr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
        load[i] <= '0;
        pred[i] <= '0;
      end
      count <= '0;
    end else begin
      if (cmd.update && (is_best || (rbit && ahead))) begin
        load[addr] <= sat;
      end
      if (cmd.rep_a) begin
        load[addr] <= item.reply_cpu_time;
        if (count != '1) begin
          count <= count + VAL_W'(1);
        end
      end
      if (cmd.rep_b) begin
        pred[addr] <= (pr == '0) ? item.reply_proc_time : ew_sum[VAL_W+2:EWMA_SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.reply_count <= count;
      if (item.command == CMD_REPLY) begin
        out_item.accepted <= 1'b0;
        out_item.chosen_worker <= '0;
        out_item.refused_count <= '0;
      end else begin
        out_item.accepted <= found;
        out_item.chosen_worker <= found ? WID_W'(best_idx) : '0;
        out_item.refused_count <= REFCNT_W'(refused);
      end
    end
  end

endmodule

// ===== rtl/lld_ctrl.sv =====
// Controller of the least-load worker dispatcher.
// Sequences capture, scan and update passes, reply steps and result hand-off.
// Depends on lld_pkg.
module lld_ctrl import lld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  lld_status_t status,
  output lld_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_UPDATE = 7'b0001000,
    ST_REP_A  = 7'b0010000,
    ST_REP_B  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.is_reply) begin
          state_next = status.reply_ok ? ST_REP_A : ST_DONE;
        end else begin
          state_next = status.n_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_REP_A: begin
        cmd.rep_a = 1'b1;
        state_next = ST_REP_B;
      end
      ST_REP_B: begin
        cmd.rep_b = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/least_load_worker_dispatcher.sv =====
// Top level of the least-load worker dispatcher.
// Joins lld_ctrl and lld_datapath; depends on lld_pkg.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   in_item (in_item_t)
//   out       output     out_valid / out_stall out_item (out_item_t)
//   cfg       input      cfg_write             cfg_data (active workers)
//
// A dispatch item makes two passes over the N active workers, one worker per cycle:
// a scan pass finds the accepting worker, a second pass applies the load updates.
// A reply from an inactive worker updates no state but still yields a result.
// Reset is synchronous and clears all loads, predictions and the reply counter.
// A new item is taken only once the previous result has moved into the output
// register, so a stalled output holds back at most one finished item.
module least_load_worker_dispatcher import lld_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  lld_cmd_t    cmd;
  lld_status_t status;

  lld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lld_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

// ===== rtl/lld_checker.sv =====
// Port-level checker for the least-load worker dispatcher, bound to the top level.
// Depends on lld_pkg.
module lld_checker import lld_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input out_item_t        out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Stalled result item changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken again right after an item was accepted.");

  a_none_chosen: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.accepted |-> out_item.chosen_worker == '0)
    else $error("Worker reported for an item that found no worker.");

  a_refused_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.accepted |->
      int'(out_item.refused_count) < MAX_WORKERS)
    else $error("Refusal count too large for an accepted item.");

endmodule

bind least_load_worker_dispatcher lld_checker u_chk (.*);
